// ----- src/touch_key_event_generator_assert.svh -----
// Assertion macros shared by the touch key event generator modules.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef TOUCH_KEY_EVENT_GENERATOR_ASSERT_SVH
`define TOUCH_KEY_EVENT_GENERATOR_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define TKEG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication: when the antecedent holds, the consequent holds in the same cycle.
`define TKEG_ASSERT_IMP(label, ante, cons, msg) \
  `TKEG_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- src/tkeg_pkg.sv -----
// Package of the touch key event generator: types, codes and reset constants.
// No dependencies; used by every module of the block.
package tkeg_pkg;

  localparam int unsigned KeyCountDefault = 12;
  localparam int unsigned MapW            = 12;
  localparam int unsigned MsW             = 16;
  localparam int unsigned KeyIdxOutW      = 4;
  localparam int unsigned OutDepth        = 4;

  localparam logic [MsW-1:0] WindowReset   = 16'd250;
  localparam logic [MsW-1:0] IntervalReset = 16'd125;

  typedef enum logic [0:0] {
    REG_DOUBLE_WINDOW   = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } tkeg_reg_e;

  typedef enum logic [1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_REPEATED = 2'd2,
    KIND_RELEASED = 2'd3
  } tkeg_kind_e;

  // One accepted input transaction, classified as tick or scan.
  typedef struct packed {
    logic            scan;
    logic [MapW-1:0] keys;
  } tkeg_item_t;

  // One result transaction.
  typedef struct packed {
    logic [KeyIdxOutW-1:0] key_index;
    tkeg_kind_e            kind;
    logic [MsW-1:0]        count;
    logic                  last;
  } tkeg_event_t;

  // Handshake between the input queue and the scan engine.
  typedef struct packed {
    logic       valid;
    tkeg_item_t item;
  } tkeg_front_t;

endpackage

// ----- src/tkeg_front.sv -----
// Input side of the touch key event generator: a two-entry queue that takes
// tick and scan transactions and presents them, classified, to the scan engine.
// Depends on tkeg_pkg.
module tkeg_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      action_i,
  input  logic [tkeg_pkg::MapW-1:0] touched_keys_i,
  output tkeg_pkg::tkeg_front_t     front_o,
  input  logic                      item_pop_i
);

  tkeg_pkg::tkeg_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = item_pop_i && (cnt_q != 2'd0);

  assign front_o.valid = (cnt_q != 2'd0);
  assign front_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Classify on entry: action high marks a scan.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q].scan <= action_i;
      mem_q[wr_ptr_q].keys <= touched_keys_i;
    end
  end

endmodule

// ----- src/tkeg_back.sv -----
// Scan engine of the touch key event generator: configuration registers, the
// shared millisecond counter, repeat count, previous bitmap and the key walk.
// Depends on tkeg_pkg and touch_key_event_generator_assert.svh.
`include "touch_key_event_generator_assert.svh"

module tkeg_back #(
  parameter int unsigned KEY_COUNT = tkeg_pkg::KeyCountDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  tkeg_pkg::tkeg_reg_e      cfg_idx_i,
  input  logic [tkeg_pkg::MsW-1:0] cfg_wdata_i,
  input  tkeg_pkg::tkeg_front_t    front_i,
  output logic                     item_pop_o,
  output logic                     ev_push_o,
  output tkeg_pkg::tkeg_event_t    ev_o,
  input  logic                     ev_full_i
);

  localparam int unsigned NumKeys =
    (KEY_COUNT < tkeg_pkg::MapW) ? KEY_COUNT : tkeg_pkg::MapW;
  localparam int unsigned KeyIdxW = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam logic [KeyIdxW-1:0] LastKey = KeyIdxW'(NumKeys - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [KeyIdxW-1:0]         key_q, key_d;
  logic [NumKeys-1:0]         now_q, now_d;
  logic [NumKeys-1:0]         prev_q, prev_d;
  logic [tkeg_pkg::MsW-1:0]   el_q, el_d;
  logic [tkeg_pkg::MsW-1:0]   rep_q, rep_d;
  logic [tkeg_pkg::MsW-1:0]   win_q, intv_q;
  logic                       pend_v_q, pend_v_d;
  tkeg_pkg::tkeg_event_t      pend_q, pend_d;

  logic                       is_t, was_t, fire, stall;
  tkeg_pkg::tkeg_kind_e       kind;
  logic [tkeg_pkg::MsW-1:0]   rep_new, el_new;

  assign is_t  = now_q[key_q];
  assign was_t = prev_q[key_q];

  // Judge the current key against the counter as earlier keys left it.
  always_comb begin
    fire    = 1'b0;
    kind    = tkeg_pkg::KIND_PRESSED;
    rep_new = rep_q;
    el_new  = el_q;
    if (is_t && !was_t) begin
      fire    = 1'b1;
      kind    = (el_q <= win_q) ? tkeg_pkg::KIND_DOUBLE : tkeg_pkg::KIND_PRESSED;
      rep_new = '0;
      el_new  = '0;
    end else if (is_t && was_t) begin
      if (el_q >= intv_q) begin
        fire    = 1'b1;
        kind    = tkeg_pkg::KIND_REPEATED;
        rep_new = rep_q + 16'd1;
        el_new  = '0;
      end
    end else if (!is_t && was_t) begin
      fire    = 1'b1;
      kind    = tkeg_pkg::KIND_RELEASED;
      rep_new = '0;
    end
  end

  assign stall = fire && pend_v_q && ev_full_i;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    now_d      = now_q;
    prev_d     = prev_q;
    el_d       = el_q;
    rep_d      = rep_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    item_pop_o = 1'b0;
    ev_push_o  = 1'b0;
    ev_o       = pend_q;
    ev_o.last  = (state_q == S_FLUSH);
    unique case (state_q)
      S_IDLE: begin
        if (front_i.valid) begin
          item_pop_o = 1'b1;
          if (front_i.item.scan) begin
            now_d   = front_i.item.keys[NumKeys-1:0];
            key_d   = '0;
            state_d = S_SCAN;
          end else if (el_q != '1) begin
            el_d = el_q + 16'd1;
          end
        end
      end
      S_SCAN: begin
        if (!stall) begin
          el_d  = el_new;
          rep_d = rep_new;
          if (fire) begin
            ev_push_o        = pend_v_q;
            pend_v_d         = 1'b1;
            pend_d.key_index = tkeg_pkg::KeyIdxOutW'(key_q);
            pend_d.kind      = kind;
            pend_d.count     = rep_new;
            pend_d.last      = 1'b0;
          end
          if (key_q == LastKey) begin
            prev_d  = now_q;
            state_d = S_FLUSH;
          end else begin
            key_d = key_q + KeyIdxW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (!ev_full_i) begin
          ev_push_o = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      key_q    <= '0;
      prev_q   <= '0;
      el_q     <= '0;
      rep_q    <= '0;
      pend_v_q <= 1'b0;
      win_q    <= tkeg_pkg::WindowReset;
      intv_q   <= tkeg_pkg::IntervalReset;
    end else begin
      state_q  <= state_d;
      key_q    <= key_d;
      prev_q   <= prev_d;
      el_q     <= el_d;
      rep_q    <= rep_d;
      pend_v_q <= pend_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tkeg_pkg::REG_DOUBLE_WINDOW:   win_q  <= cfg_wdata_i;
          tkeg_pkg::REG_REPEAT_INTERVAL: intv_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    pend_q <= pend_d;
  end

  `TKEG_ASSERT_IMP(a_key_in_range, state_q == S_SCAN, key_q <= LastKey, "key index past last key")
  `TKEG_ASSERT_IMP(a_no_push_full, ev_push_o, !ev_full_i, "event pushed into full queue")
  `TKEG_ASSERT(a_flush_drains, (state_q == S_FLUSH && state_d == S_IDLE) |=> !pend_v_q, "pending event left after scan")

endmodule

// ----- src/tkeg_outq.sv -----
// Result queue of the touch key event generator: holds finished events until
// they are popped. Depends on tkeg_pkg and touch_key_event_generator_assert.svh.
`include "touch_key_event_generator_assert.svh"

module tkeg_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ev_push_i,
  input  tkeg_pkg::tkeg_event_t ev_i,
  output logic                  ev_full_o,
  output logic                  empty,
  input  logic                  pop,
  output tkeg_pkg::tkeg_event_t ev_o
);

  localparam int unsigned PtrW = $clog2(tkeg_pkg::OutDepth);
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [CntW-1:0] Depth = CntW'(tkeg_pkg::OutDepth);

  tkeg_pkg::tkeg_event_t mem_q [tkeg_pkg::OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ev_full_o = (cnt_q == Depth);
  assign empty     = (cnt_q == '0);
  assign do_push   = ev_push_i && !ev_full_o;
  assign do_pop    = pop && !empty;
  assign ev_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= ev_i;
    end
  end

  `TKEG_ASSERT(a_cnt_bound, cnt_q <= Depth, "result queue count overflow")
  `TKEG_ASSERT(a_idle_hold, (!ev_push_i && !pop) |=> $stable(cnt_q), "result queue count moved while idle")

endmodule

// ----- src/touch_key_event_generator.sv -----
// Touch key event generator. Accepts two kinds of input transaction on a queue
// style port: a one-millisecond tick (action_i low), which advances a shared
// saturating millisecond counter, and a scan (action_i high) with the touch
// bitmap of up to twelve keys. A scan walks the keys in order, one key per
// cycle while the result queue has room. The scan engine loads the bitmap,
// then takes the keys one at a time, then marks the final event, and waits
// while the result queue is full. Each key's change may clear the counter
// and the repeat count before the next key is judged. New touches give
// pressed or double pressed, held keys that reach the repeat interval give
// repeated, releases give released; the final event of a scan carries
// last_of_scan_o. Inputs wait in a two-entry queue and results in a
// four-entry queue, so either side may stall on its own. Write the two
// configuration registers (double press window, repeat interval) only while
// the block is idle.
// Depends on tkeg_pkg, tkeg_front, tkeg_back and tkeg_outq.
module touch_key_event_generator #(
  parameter int unsigned KEY_COUNT = tkeg_pkg::KeyCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  tkeg_pkg::tkeg_reg_e             cfg_idx_i,
  input  logic [tkeg_pkg::MsW-1:0]        cfg_wdata_i,
  // Input transactions
  input  logic                            push,
  output logic                            full,
  input  logic                            action_i,
  input  logic [tkeg_pkg::MapW-1:0]       touched_keys_i,
  // Result transactions
  output logic                            empty,
  input  logic                            pop,
  output logic [tkeg_pkg::KeyIdxOutW-1:0] key_index_o,
  output logic [1:0]                      event_kind_o,
  output logic [tkeg_pkg::MsW-1:0]        repeat_count_o,
  output logic                            last_of_scan_o
);

  tkeg_pkg::tkeg_front_t front;
  tkeg_pkg::tkeg_event_t ev_in, ev_out;
  logic                  item_pop, ev_push, ev_full;

  // Accept and classify input transactions.
  tkeg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .touched_keys_i (touched_keys_i),
    .front_o        (front),
    .item_pop_i     (item_pop)
  );

  // Advance the counter on ticks; walk the keys on scans.
  tkeg_back #(
    .KEY_COUNT (KEY_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .front_i     (front),
    .item_pop_o  (item_pop),
    .ev_push_o   (ev_push),
    .ev_o        (ev_in),
    .ev_full_i   (ev_full)
  );

  // Hold finished events until popped.
  tkeg_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_push_i (ev_push),
    .ev_i      (ev_in),
    .ev_full_o (ev_full),
    .empty     (empty),
    .pop       (pop),
    .ev_o      (ev_out)
  );

  assign key_index_o    = ev_out.key_index;
  assign event_kind_o   = ev_out.kind;
  assign repeat_count_o = ev_out.count;
  assign last_of_scan_o = ev_out.last;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for touch_key_event_generator: drives ticks and key scans, predicts
// every key event and checks each result transaction in order.
// Depends on tkeg_pkg and the RTL of the block; needs no other file.
module tb;

  localparam int unsigned KEY_COUNT = tkeg_pkg::KeyCountDefault;

  // Input action codes.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  // Cycles to let pass after the last expected event before a config write
  // or the end: a scan with no change still keeps the engine busy walking
  // every key, and two more may wait in the input queue.
  localparam int SETTLE_CYCLES  = 64;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 200_000;
  localparam int MAX_PRINTED    = 40;

  localparam int NUM_PHASES      = 6;
  localparam int STEPS_PER_PHASE = 16;

  typedef struct packed {
    logic [tkeg_pkg::KeyIdxOutW-1:0] key;
    tkeg_pkg::tkeg_kind_e            kind;
    logic [tkeg_pkg::MsW-1:0]        count;
    logic                            last;
  } key_event_t;

  localparam key_event_t NO_EVENT = '0;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_TICK,
    ROW_SCAN
  } row_kind_e;

  // One line of the directed table. Config rows use window and interval;
  // typed rows carry the single event that the scan must give.
  typedef struct {
    row_kind_e                 kind;
    logic [tkeg_pkg::MapW-1:0] keys;
    int                        reps;
    logic [tkeg_pkg::MsW-1:0]  window;
    logic [tkeg_pkg::MsW-1:0]  interval;
    bit                        typed;
    key_event_t                want;
  } dir_row_t;

  localparam int NUM_ROWS = 24;

  dir_row_t dir_rows [NUM_ROWS] = '{
    // Reset settings: a scan with nothing touched gives nothing.
    '{ROW_SCAN, 12'h000, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    // First touch right after reset falls inside the double press window.
    '{ROW_SCAN, 12'h001, 1, 16'd0, 16'd0, 1'b1, '{4'd0, tkeg_pkg::KIND_DOUBLE, 16'd0, 1'b1}},
    '{ROW_SCAN, 12'h000, 1, 16'd0, 16'd0, 1'b1, '{4'd0, tkeg_pkg::KIND_RELEASED, 16'd0, 1'b1}},
    // Zero window and interval: key 0 sees one tick and gives pressed, the
    // cleared counter makes every later key a double press.
    '{ROW_CFG,  12'h000, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_TICK, 12'hA5A, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'hFFF, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'hFFF, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'h000, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    // Top settings: the highest key alone.
    '{ROW_CFG,  12'h000, 1, 16'hFFFF, 16'hFFFF, 1'b0, NO_EVENT},
    '{ROW_TICK, 12'hFFF, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'h800, 1, 16'd0, 16'd0, 1'b1, '{4'd11, tkeg_pkg::KIND_DOUBLE, 16'd0, 1'b1}},
    // Held below the interval: no event.
    '{ROW_SCAN, 12'h800, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    // Interval of three ticks: the held key repeats once, then releases.
    '{ROW_CFG,  12'h000, 1, 16'hFFFF, 16'd3, 1'b0, NO_EVENT},
    '{ROW_TICK, 12'h5A5, 3, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'h800, 1, 16'd0, 16'd0, 1'b1,
      '{4'd11, tkeg_pkg::KIND_REPEATED, 16'd1, 1'b1}},
    '{ROW_SCAN, 12'h000, 1, 16'd0, 16'd0, 1'b1,
      '{4'd11, tkeg_pkg::KIND_RELEASED, 16'd0, 1'b1}},
    // Touch all keys, then hold them with a zero interval: every key repeats on every later scan.
    '{ROW_CFG,  12'h000, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'hFFF, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'hFFF, 3, 16'd0, 16'd0, 1'b0, NO_EVENT},
    // Mixed scans: releases beside held keys, then releases beside new touches.
    '{ROW_SCAN, 12'h555, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'hAAA, 1, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_TICK, 12'hFFF, 3, 16'd0, 16'd0, 1'b0, NO_EVENT},
    '{ROW_CFG,  12'h000, 1, tkeg_pkg::WindowReset, tkeg_pkg::IntervalReset, 1'b0, NO_EVENT},
    '{ROW_SCAN, 12'h000, 1, 16'd0, 16'd0, 1'b0, NO_EVENT}
  };

  // DUT interface.
  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_we_i       = 1'b0;
  tkeg_pkg::tkeg_reg_e             cfg_idx_i      = tkeg_pkg::REG_DOUBLE_WINDOW;
  logic [tkeg_pkg::MsW-1:0]        cfg_wdata_i    = '0;
  logic                            push           = 1'b0;
  logic                            full;
  logic                            action_i       = ACT_TICK;
  logic [tkeg_pkg::MapW-1:0]       touched_keys_i = '0;
  logic                            empty;
  logic                            pop            = 1'b0;
  logic [tkeg_pkg::KeyIdxOutW-1:0] key_index_o;
  logic [1:0]                      event_kind_o;
  logic [tkeg_pkg::MsW-1:0]        repeat_count_o;
  logic                            last_of_scan_o;

  // Predictor state and its copy of the configuration.
  logic [tkeg_pkg::MapW-1:0] held_map       = '0;
  logic [tkeg_pkg::MsW-1:0]  ms_since_event = '0;
  logic [tkeg_pkg::MsW-1:0]  repeat_tally   = '0;
  logic [tkeg_pkg::MsW-1:0]  cfg_window     = tkeg_pkg::WindowReset;
  logic [tkeg_pkg::MsW-1:0]  cfg_interval   = tkeg_pkg::IntervalReset;

  key_event_t pending_events [$];

  int  err_count   = 0;
  int  cycle_count = 0;
  bit  tx_no_gap   = 1'b0;
  bit  rx_no_gap   = 1'b0;
  bit  rx_hold_req = 1'b0;

  touch_key_event_generator #(
    .KEY_COUNT(KEY_COUNT)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .touched_keys_i(touched_keys_i),
    .empty         (empty),
    .pop           (pop),
    .key_index_o   (key_index_o),
    .event_kind_o  (event_kind_o),
    .repeat_count_o(repeat_count_o),
    .last_of_scan_o(last_of_scan_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    end
    err_count++;
  endtask

  // Walk the keys in order; each event may clear the shared counter and the
  // repeat count before the next key is judged. Append the events of the scan
  // to the expected store and return how many there were.
  function automatic int predict_scan_events(input logic [tkeg_pkg::MapW-1:0] map);
    key_event_t found [$];
    key_event_t ev;
    bit         fire;
    for (int k = 0; k < KEY_COUNT; k++) begin
      ev     = '0;
      ev.key = tkeg_pkg::KeyIdxOutW'(k);
      fire   = 1'b0;
      if (map[k] && !held_map[k]) begin
        ev.kind        = (ms_since_event <= cfg_window) ? tkeg_pkg::KIND_DOUBLE
                                                        : tkeg_pkg::KIND_PRESSED;
        repeat_tally   = '0;
        ms_since_event = '0;
        fire           = 1'b1;
      end else if (map[k] && held_map[k]) begin
        if (ms_since_event >= cfg_interval) begin
          ev.kind        = tkeg_pkg::KIND_REPEATED;
          repeat_tally   = repeat_tally + 16'd1;
          ms_since_event = '0;
          fire           = 1'b1;
        end
      end else if (!map[k] && held_map[k]) begin
        ev.kind      = tkeg_pkg::KIND_RELEASED;
        repeat_tally = '0;
        fire         = 1'b1;
      end
      if (fire) begin
        ev.count = repeat_tally;
        found.push_back(ev);
      end
    end
    if (found.size() > 0) begin
      found[found.size()-1].last = 1'b1;
    end
    foreach (found[i]) begin
      pending_events.push_back(found[i]);
    end
    held_map = map;
    return found.size();
  endfunction

  function automatic int tx_gap();
    return tx_no_gap ? 0 : $urandom_range(0, 3);
  endfunction

  // Offer one input transaction after gap idle cycles and hold it until the
  // block takes it; predict at the accepting edge. Leave push high: the
  // caller drives it again in the same step.
  task automatic send_item(input logic act, input logic [tkeg_pkg::MapW-1:0] keys,
                           input int gap, output int produced);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    action_i       <= act;
    touched_keys_i <= keys;
    do @(posedge clk_i); while (full);
    produced = 0;
    if (act == ACT_TICK) begin
      if (ms_since_event != 16'hFFFF) ms_since_event = ms_since_event + 16'd1;
    end else begin
      produced = predict_scan_events(keys);
    end
  endtask

  // Drop push, wait for every expected event, then let the engine finish
  // any scan that gives nothing.
  task automatic settle_idle();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [tkeg_pkg::MsW-1:0] win,
                              input logic [tkeg_pkg::MsW-1:0] ivl);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tkeg_pkg::REG_DOUBLE_WINDOW;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_idx_i   <= tkeg_pkg::REG_REPEAT_INTERVAL;
    cfg_wdata_i <= ivl;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    cfg_window   = win;
    cfg_interval = ivl;
  endtask

  // Result side: pop with random idling, one long hold-off on request, and
  // check each transaction against the oldest expected event.
  initial begin : drain_results
    int         gap;
    key_event_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      gap = rx_no_gap ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_events.size() == 0) begin
        report_error($sformatf("unexpected event key %0d kind %0d count %0d",
                               key_index_o, event_kind_o, repeat_count_o));
      end else begin
        want = pending_events.pop_front();
        if (key_index_o !== want.key)
          report_error($sformatf("key_index got %0d, expected %0d", key_index_o, want.key));
        if (event_kind_o !== want.kind)
          report_error($sformatf("event_kind got %0d, expected %0d (key %0d)",
                                 event_kind_o, want.kind, want.key));
        if (repeat_count_o !== want.count)
          report_error($sformatf("repeat_count got %0d, expected %0d (key %0d)",
                                 repeat_count_o, want.count, want.key));
        if (last_of_scan_o !== want.last)
          report_error($sformatf("last_of_scan got %0d, expected %0d (key %0d)",
                                 last_of_scan_o, want.last, want.key));
      end
    end
  end

  initial begin : stimulus
    int                        produced;
    int                        steps;
    int                        pick;
    int                        burst;
    int                        mode;
    logic [tkeg_pkg::MapW-1:0] map;
    logic [tkeg_pkg::MsW-1:0]  win;
    logic [tkeg_pkg::MsW-1:0]  ivl;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_CFG: begin
          write_config(dir_rows[r].window, dir_rows[r].interval);
        end
        ROW_TICK, ROW_SCAN: begin
          for (int i = 0; i < dir_rows[r].reps; i++) begin
            send_item((dir_rows[r].kind == ROW_SCAN) ? ACT_SCAN : ACT_TICK, dir_rows[r].keys,
                      tx_gap(), produced);
            // Typed rows: replace what the predictor queued by the value read
            // off the table.
            if (dir_rows[r].typed) begin
              repeat (produced) void'(pending_events.pop_back());
              pending_events.push_back(dir_rows[r].want);
            end
          end
        end
        default: ;
      endcase
    end

    // Random phases, each under its own settings. The first four walk small
    // random values, full random values, extremes and the reset values.
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = (p < 4) ? p : $urandom_range(0, 3);
      case (mode)
        0: begin
          win = 16'($urandom_range(0, 40));
          ivl = 16'($urandom_range(0, 20));
        end
        1: begin
          win = 16'($urandom);
          ivl = 16'($urandom);
        end
        2: begin
          win = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
          ivl = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        end
        default: begin
          win = tkeg_pkg::WindowReset;
          ivl = tkeg_pkg::IntervalReset;
        end
      endcase
      write_config(win, ivl);
      tx_no_gap = ($urandom_range(0, 3) == 0);
      rx_no_gap = ($urandom_range(0, 3) == 0);
      // Hold the result side off once while a scan that flips every key and
      // the items after it keep coming, so both queues fill and the input
      // stalls.
      if (p == 0) begin
        rx_hold_req = 1'b1;
        send_item(ACT_SCAN, ~held_map, tx_gap(), produced);
      end

      for (steps = 0; steps < STEPS_PER_PHASE; steps++) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
          burst = $urandom_range(1, 8);
          repeat (burst) send_item(ACT_TICK, tkeg_pkg::MapW'($urandom), tx_gap(), produced);
        end else if (pick == 6) begin
          // Long idle stretch: carry the counter past small window and
          // interval settings.
          burst = $urandom_range(20, 40);
          repeat (burst) send_item(ACT_TICK, tkeg_pkg::MapW'($urandom), 0, produced);
        end else if (pick < 15) begin
          // Well-formed change: touch or release a few keys.
          map = held_map;
          repeat ($urandom_range(0, 3)) map[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
          send_item(ACT_SCAN, map, tx_gap(), produced);
        end else if (pick < 18) begin
          send_item(ACT_SCAN, held_map, tx_gap(), produced);
        end else begin
          send_item(ACT_SCAN, tkeg_pkg::MapW'($urandom), tx_gap(), produced);
        end
      end
    end

    // Drain and report.
    settle_idle();
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
